### rtl/fixed_radius_neighbor_scan_macros.svh
// Assertion macros used by the neighbour scan top level.
`ifndef FIXED_RADIUS_NEIGHBOR_SCAN_MACROS_SVH
`define FIXED_RADIUS_NEIGHBOR_SCAN_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define FRNS_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("neighbour scan check failed");

// Check a condition in the cycle after its trigger.
`define FRNS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("neighbour scan check failed");

`endif

### rtl/frns_pkg.sv
// Types and constants of the fixed radius neighbour scan.
package frns_pkg;

    localparam int NODE_BITS  = 6;
    localparam int NODES      = 1 << NODE_BITS;
    localparam int COORD_BITS = 16;
    localparam int RSQ_BITS   = 2 * COORD_BITS + 3;
    localparam int CNT_BITS   = 4;
    localparam int IMAGES     = 9;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(NODES - 1);

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RADIUS_SQ = 1'b0,
        CFG_PERIODIC  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LATCH,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic                  func;
        logic [NODE_BITS-1:0]  node;
        logic [COORD_BITS-1:0] x_pos;
        logic [COORD_BITS-1:0] y_pos;
    } t_in_item;

    typedef struct packed {
        logic [NODE_BITS-1:0] neighbor;
        logic [CNT_BITS-1:0]  match_count;
        logic                 found;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_pos;

    // Candidate node travelling alongside the distance pipeline.
    typedef struct packed {
        logic                 vld;
        logic [NODE_BITS-1:0] idx;
    } t_tag;

    // Position memory request from the sequencer.
    typedef struct packed {
        logic                 wr_en;
        logic [NODE_BITS-1:0] wr_addr;
        logic                 rd_en;
        logic [NODE_BITS-1:0] rd_addr;
    } t_mem_req;

endpackage

### rtl/fixed_radius_neighbor_scan.sv
// Top level of the fixed radius neighbour scan.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | in        | i_in_valid / o_in_stall | i_in_item  (func, node, x, y)
//  out     | out       | o_out_valid / i_out_stall | o_out_item (neighbor, count, flags)
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load goes straight into the position memory.
// A query of node i below the last node reads node i, latches it as the reference,
// then issues one memory read per higher node j through the single read port,
// then drains the distance pipeline and flushes the last result. A query of the
// last node goes straight to the drain and flush.
// A stalled output freezes the scan and the drain, memory read register included.
// Reset clears control state and the configuration registers; positions are undefined until loaded.
`include "fixed_radius_neighbor_scan_macros.svh"

module fixed_radius_neighbor_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  frns_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output frns_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [frns_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [frns_pkg::RSQ_BITS-1:0]     i_cfg_data
);

    logic [frns_pkg::RSQ_BITS-1:0] r_radius_sq;
    logic                          r_periodic;

    frns_pkg::t_mem_req w_mem;
    frns_pkg::t_pos     w_wr_data;
    frns_pkg::t_pos     w_rd_data;
    frns_pkg::t_tag     w_tag0;
    frns_pkg::t_tag     w_res;
    logic [frns_pkg::CNT_BITS-1:0] w_count;
    logic w_adv, w_ref_load, w_pipe_busy;
    logic w_query_take, w_has_count;

    // Registers are only to be written between items, which the user must ensure, so always take the write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_sq <= '0;
            r_periodic  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (frns_pkg::t_cfg_reg'(i_cfg_index))
                frns_pkg::CFG_RADIUS_SQ: r_radius_sq <= i_cfg_data;
                frns_pkg::CFG_PERIODIC:  r_periodic  <= i_cfg_data[0];
                default: r_periodic <= r_periodic;
            endcase
        end
    end

    assign w_wr_data.x = i_in_item.x_pos;
    assign w_wr_data.y = i_in_item.y_pos;

    frns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_mem       (w_mem),
        .o_ref_load  (w_ref_load),
        .o_adv       (w_adv),
        .o_tag0      (w_tag0),
        .i_res       (w_res),
        .i_count     (w_count),
        .i_pipe_busy (w_pipe_busy)
    );

    frns_pos_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem.wr_en),
        .i_wr_addr (w_mem.wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr),
        .o_rd_data (w_rd_data)
    );

    frns_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_ref_load  (w_ref_load),
        .i_tag       (w_tag0),
        .i_rd_data   (w_rd_data),
        .i_radius_sq (r_radius_sq),
        .i_periodic  (r_periodic),
        .o_tag       (w_res),
        .o_count     (w_count),
        .o_busy      (w_pipe_busy)
    );

    assign w_query_take = i_in_valid && !o_in_stall &&
                          (i_in_item.func == frns_pkg::FUNC_QUERY);
    assign w_has_count  = (o_out_item.match_count != '0);

    // A real neighbour always carries a count, the marker never does.
    `FRNS_ASSERT_NOW(a_found_count, i_clk, i_rst_n, o_out_valid, (o_out_item.found == w_has_count))
    // A query holds off further items once taken.
    `FRNS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_query_take, o_in_stall)
    // A result that is not last means the query is still running.
    `FRNS_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, (o_out_valid && !o_out_item.last), o_in_stall)

endmodule

### rtl/frns_pos_mem.sv
// Position memory: one write port, one registered read port.
module frns_pos_mem (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [frns_pkg::NODE_BITS-1:0] i_wr_addr,
    input  frns_pkg::t_pos                 i_wr_data,
    input  logic                           i_rd_en,
    input  logic [frns_pkg::NODE_BITS-1:0] i_rd_addr,
    output frns_pkg::t_pos                 o_rd_data
);

    frns_pkg::t_pos r_mem [frns_pkg::NODES];
    frns_pkg::t_pos r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold the read data while the scan is paused.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/frns_dist.sv
// Image distance pipeline: magnitudes, squares, radius compare.
module frns_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_ref_load,
    input  frns_pkg::t_tag                i_tag,
    input  frns_pkg::t_pos                i_rd_data,
    input  logic [frns_pkg::RSQ_BITS-1:0] i_radius_sq,
    input  logic                          i_periodic,
    output frns_pkg::t_tag                o_tag,
    output logic [frns_pkg::CNT_BITS-1:0] o_count,
    output logic                          o_busy
);

    localparam int DIFF_BITS = frns_pkg::COORD_BITS + 2;
    localparam int MAG_BITS  = frns_pkg::COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam logic signed [DIFF_BITS-1:0] UNIT = DIFF_BITS'(1 << frns_pkg::COORD_BITS);

    function automatic logic [MAG_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] v);
        logic signed [DIFF_BITS-1:0] a;
        a = v[DIFF_BITS-1] ? -v : v;
        return a[MAG_BITS-1:0];
    endfunction

    frns_pkg::t_pos r_ref;
    frns_pkg::t_tag r_tag_a, r_tag_b, r_tag_c;
    logic [MAG_BITS-1:0] r_ax [3];
    logic [MAG_BITS-1:0] r_ay [3];
    logic [SQ_BITS-1:0]  r_sx [3];
    logic [SQ_BITS-1:0]  r_sy [3];
    logic [frns_pkg::IMAGES-1:0] r_hit;

    logic signed [DIFF_BITS-1:0] w_dx0, w_dy0;
    logic [MAG_BITS-1:0] w_ax [3];
    logic [MAG_BITS-1:0] w_ay [3];
    logic [frns_pkg::IMAGES-1:0] w_hit;
    logic [frns_pkg::RSQ_BITS-1:0] w_sum;
    logic [frns_pkg::CNT_BITS-1:0] w_count;

    // Image order: shift -1, 0, +1; the shift -1 image adds one unit to the difference.
    always_comb begin
        w_dx0 = $signed(DIFF_BITS'(r_ref.x)) - $signed(DIFF_BITS'(i_rd_data.x));
        w_dy0 = $signed(DIFF_BITS'(r_ref.y)) - $signed(DIFF_BITS'(i_rd_data.y));
        w_ax[0] = mag(w_dx0 + UNIT);
        w_ax[1] = mag(w_dx0);
        w_ax[2] = mag(w_dx0 - UNIT);
        w_ay[0] = mag(w_dy0 + UNIT);
        w_ay[1] = mag(w_dy0);
        w_ay[2] = mag(w_dy0 - UNIT);
    end

    // Only the centre image counts outside periodic mode.
    always_comb begin
        w_sum = '0;
        for (int kx = 0; kx < 3; kx++) begin
            for (int ky = 0; ky < 3; ky++) begin
                w_sum = frns_pkg::RSQ_BITS'(r_sx[kx]) + frns_pkg::RSQ_BITS'(r_sy[ky]);
                w_hit[3*kx+ky] = (w_sum < i_radius_sq) &&
                                 (i_periodic || (kx == 1 && ky == 1));
            end
        end
    end

    always_comb begin
        w_count = '0;
        for (int k = 0; k < frns_pkg::IMAGES; k++) begin
            w_count = w_count + frns_pkg::CNT_BITS'(r_hit[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a.vld <= 1'b0;
            r_tag_b.vld <= 1'b0;
            r_tag_c.vld <= 1'b0;
        end else if (i_adv) begin
            r_tag_a.vld <= i_tag.vld;
            r_tag_b.vld <= r_tag_a.vld;
            r_tag_c.vld <= r_tag_b.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ref_load) begin
            r_ref <= i_rd_data;
        end
        if (i_adv) begin
            r_tag_a.idx <= i_tag.idx;
            r_tag_b.idx <= r_tag_a.idx;
            r_tag_c.idx <= r_tag_b.idx;
            for (int k = 0; k < 3; k++) begin
                r_ax[k] <= w_ax[k];
                r_ay[k] <= w_ay[k];
                r_sx[k] <= r_ax[k] * r_ax[k];
                r_sy[k] <= r_ay[k] * r_ay[k];
            end
            r_hit <= w_hit;
        end
    end

    assign o_tag   = r_tag_c;
    assign o_count = w_count;
    assign o_busy  = r_tag_a.vld | r_tag_b.vld | r_tag_c.vld;

endmodule

### rtl/frns_ctrl.sv
// Scan sequencer: item intake, address issue, result hold and output register.
module frns_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  frns_pkg::t_in_item            i_in_item,
    output logic                          o_in_stall,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output frns_pkg::t_out_item           o_out_item,
    output frns_pkg::t_mem_req            o_mem,
    output logic                          o_ref_load,
    output logic                          o_adv,
    output frns_pkg::t_tag                o_tag0,
    input  frns_pkg::t_tag                i_res,
    input  logic [frns_pkg::CNT_BITS-1:0] i_count,
    input  logic                          i_pipe_busy
);

    frns_pkg::t_state r_state, n_state;
    logic [frns_pkg::NODE_BITS-1:0] r_j, n_j;
    frns_pkg::t_tag r_tag0;
    logic r_pend_v, n_pend_v;
    logic [frns_pkg::NODE_BITS-1:0] r_pend_idx, n_pend_idx;
    logic [frns_pkg::CNT_BITS-1:0]  r_pend_cnt, n_pend_cnt;
    logic r_out_valid, n_out_valid;
    frns_pkg::t_out_item r_out, n_out;

    logic w_accept, w_query, w_adv, w_done, w_hit;

    assign w_adv    = !r_out_valid || !i_out_stall;
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_query  = (i_in_item.func == frns_pkg::FUNC_QUERY);
    assign w_done   = (r_state == frns_pkg::S_DRAIN) && w_adv && !r_tag0.vld && !i_pipe_busy;
    assign w_hit    = i_res.vld && (i_count != '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            frns_pkg::S_IDLE: begin
                if (w_accept && w_query) begin
                    n_state = (i_in_item.node == frns_pkg::LAST_NODE) ?
                              frns_pkg::S_DRAIN : frns_pkg::S_LATCH;
                end
            end
            frns_pkg::S_LATCH: begin
                n_state = frns_pkg::S_SCAN;
            end
            frns_pkg::S_SCAN: begin
                if (w_adv && r_j == frns_pkg::LAST_NODE) begin
                    n_state = frns_pkg::S_DRAIN;
                end
            end
            frns_pkg::S_DRAIN: begin
                if (w_done) begin
                    n_state = frns_pkg::S_IDLE;
                end
            end
            default: n_state = frns_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall    = 1'b1;
        o_ref_load    = 1'b0;
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = i_in_item.node;
        o_mem.rd_en   = 1'b0;
        o_mem.rd_addr = r_j;
        case (r_state)
            frns_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_mem.wr_en   = i_in_valid && !w_query;
                o_mem.rd_en   = i_in_valid && w_query;
                o_mem.rd_addr = i_in_item.node;
            end
            frns_pkg::S_LATCH: begin
                o_ref_load = 1'b1;
            end
            frns_pkg::S_SCAN: begin
                o_mem.rd_en = w_adv;
            end
            frns_pkg::S_DRAIN: begin
                o_mem.rd_en = 1'b0;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // Candidate counter, result hold and output register.
    always_comb begin
        n_j         = r_j;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        n_pend_cnt  = r_pend_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_accept) begin
            n_j = i_in_item.node + frns_pkg::NODE_BITS'(1);
        end else if (r_state == frns_pkg::S_SCAN && w_adv) begin
            n_j = r_j + frns_pkg::NODE_BITS'(1);
        end
        if (w_adv) begin
            n_out_valid = 1'b0;
            if (w_done) begin
                // Flush the held match as last, or send the empty marker.
                n_out_valid          = 1'b1;
                n_out.neighbor       = r_pend_v ? r_pend_idx : '0;
                n_out.match_count    = r_pend_v ? r_pend_cnt : '0;
                n_out.found          = r_pend_v;
                n_out.last           = 1'b1;
                n_pend_v             = 1'b0;
            end else if (w_hit) begin
                // Release the older match, hold the new one.
                n_out_valid          = r_pend_v;
                n_out.neighbor       = r_pend_idx;
                n_out.match_count    = r_pend_cnt;
                n_out.found          = 1'b1;
                n_out.last           = 1'b0;
                n_pend_v             = 1'b1;
                n_pend_idx           = i_res.idx;
                n_pend_cnt           = i_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frns_pkg::S_IDLE;
            r_tag0.vld  <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
            if (w_adv) begin
                r_tag0.vld <= (r_state == frns_pkg::S_SCAN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_pend_idx <= n_pend_idx;
        r_pend_cnt <= n_pend_cnt;
        r_out      <= n_out;
        if (w_adv) begin
            r_tag0.idx <= r_j;
        end
    end

    assign o_adv       = w_adv;
    assign o_tag0      = r_tag0;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
